### rtl/core/chip8fe_pkg.sv
// Shared types, sizes and opcode codes for the CHIP-8 fetch/execute core.
package chip8fe_pkg;

	// Byte memory size (a power of two) and derived address widths
	localparam int MEM_BYTES     = 4096;
	localparam int ADDR_W        = $clog2(MEM_BYTES);
	localparam int BANK_DEPTH    = MEM_BYTES / 2;
	localparam int BANK_AW       = ADDR_W - 1;
	localparam int PC_W          = 12;
	localparam int PROGRAM_START = 512;
	localparam int NUM_REGS      = 16;
	localparam int REG_AW        = $clog2(NUM_REGS);

	// Transaction command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Opcode groups (top nibble of the instruction)
	localparam logic [3:0] OP_JP      = 4'h1;
	localparam logic [3:0] OP_SE_IMM  = 4'h3;
	localparam logic [3:0] OP_SNE_IMM = 4'h4;
	localparam logic [3:0] OP_SE_REG  = 4'h5;
	localparam logic [3:0] OP_LD_IMM  = 4'h6;
	localparam logic [3:0] OP_ADD_IMM = 4'h7;
	localparam logic [3:0] OP_SNE_REG = 4'h9;
	localparam logic [3:0] OP_LD_I    = 4'hA;
	localparam logic [3:0] OP_JP_V0   = 4'hB;
	localparam logic [3:0] OP_RND     = 4'hC;

	typedef enum logic [1:0] {
		ST_EXECUTED = 2'd0,
		ST_UNIMPL   = 2'd1,
		ST_LOADED   = 2'd2
	} status_t;

	// Program memory instruction fetch request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] hi_addr;
		logic [ADDR_W-1:0] lo_addr;
	} mem_rd_req_t;

	// Program memory byte write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_req_t;

	// Register file read request (two ports)
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] a_addr;
		logic [REG_AW-1:0] b_addr;
	} rf_rd_req_t;

	// Register file write request
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [7:0]        data;
	} rf_wr_req_t;

	// Outcome of executing one instruction
	typedef struct packed {
		status_t           status;
		logic [PC_W-1:0]   next_pc;
		logic [PC_W-1:0]   next_index;
		logic              reg_wr;
		logic [REG_AW-1:0] wreg;
		logic [7:0]        wval;
	} exec_res_t;

endpackage

### rtl/core/chip8fe_fetch_execute_core_top.sv
// A transaction passes stage 1 (memory fetch), stage 2 (register read, execute) and the
// result register. Loads are taken one per cycle while no step is in flight and the output
// does not stall; a step holds off input until it has executed, since the next fetch needs the pc it writes.
// Reset: asynchronous; pc = 0x200, index and registers zero; the program memory is
// then cleared, 2048 rows of both banks, during which no input is accepted.
module chip8_fetch_execute_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] next_pc,
	output logic [11:0] index_value,
	output logic        reg_written,
	output logic [3:0]  written_reg,
	output logic [7:0]  written_value,
	output logic [15:0] fetched_instruction
);
	import chip8fe_pkg::*;

	// Architectural registers
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] index_q;

	// Pipeline stages
	logic        valid_s1, cmd_s1;
	logic [7:0]  rand_s1;
	logic        valid_s2, cmd_s2;
	logic [7:0]  rand_s2;
	logic [15:0] insn_s2;

	// Output register
	logic              out_valid_q;
	status_t           status_q;
	logic [PC_W-1:0]   next_pc_q;
	logic [PC_W-1:0]   index_value_q;
	logic              reg_written_q;
	logic [REG_AW-1:0] written_reg_q;
	logic [7:0]        written_value_q;
	logic [15:0]       insn_q;

	logic        accept, adv1, adv2, s1_free, s2_free, step_busy, clearing;
	logic [7:0]  rd_hi, rd_lo, rd_a, rd_b;
	logic [PC_W-1:0] pc_plus1;
	mem_rd_req_t mem_rd;
	mem_wr_req_t mem_wr;
	rf_rd_req_t  rf_rd;
	rf_wr_req_t  rf_wr;
	exec_res_t   res;

	// Flow control: a step holds the front until it has executed
	assign adv2      = valid_s2 && (!out_valid_q || !out_stall);
	assign s2_free   = !valid_s2 || adv2;
	assign adv1      = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || adv1;
	assign step_busy = (valid_s1 && cmd_s1 == CMD_STEP) || (valid_s2 && cmd_s2 == CMD_STEP);
	assign in_stall  = clearing || !s1_free || step_busy;
	assign accept    = in_valid && !in_stall;

	// Instruction fetch and byte load at acceptance
	assign pc_plus1       = pc_q + PC_W'(1);
	assign mem_rd.en      = accept && command == CMD_STEP;
	assign mem_rd.hi_addr = pc_q[ADDR_W-1:0];
	assign mem_rd.lo_addr = pc_plus1[ADDR_W-1:0];
	assign mem_wr.en      = accept && command == CMD_LOAD;
	assign mem_wr.addr    = load_address[ADDR_W-1:0];
	assign mem_wr.data    = load_byte;

	chip8fe_prog_mem u_prog_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_req   (mem_rd),
		.wr_req   (mem_wr),
		.rd_hi    (rd_hi),
		.rd_lo    (rd_lo),
		.clearing (clearing)
	);

	// Register read: Vx, and V0 for the indexed jump or else Vy
	assign rf_rd.en     = adv1 && cmd_s1 == CMD_STEP;
	assign rf_rd.a_addr = rd_hi[3:0];
	assign rf_rd.b_addr = (rd_hi[7:4] == OP_JP_V0) ? REG_AW'(0) : rd_lo[7:4];

	assign rf_wr.en   = adv2 && cmd_s2 == CMD_STEP && res.reg_wr;
	assign rf_wr.addr = res.wreg;
	assign rf_wr.data = res.wval;

	chip8fe_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (rf_rd),
		.wr_req (rf_wr),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	chip8fe_execute u_execute (
		.insn      (insn_s2),
		.vx        (rd_a),
		.vb        (rd_b),
		.rand_byte (rand_s2),
		.pc        (pc_q),
		.index     (index_q),
		.res       (res)
	);

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= PC_W'(PROGRAM_START);
			index_q     <= '0;
		end else begin
			if (s1_free) valid_s1 <= accept;
			if (s2_free) valid_s2 <= adv1;
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv2 && cmd_s2 == CMD_STEP) begin
				pc_q    <= res.next_pc;
				index_q <= res.next_index;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			rand_s1 <= random_byte;
		end
		if (adv1) begin
			cmd_s2  <= cmd_s1;
			rand_s2 <= rand_s1;
			insn_s2 <= (cmd_s1 == CMD_STEP) ? {rd_hi, rd_lo} : 16'h0000;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv2) begin
			if (cmd_s2 == CMD_STEP) begin
				status_q        <= res.status;
				next_pc_q       <= res.next_pc;
				index_value_q   <= res.next_index;
				reg_written_q   <= res.reg_wr;
				written_reg_q   <= res.wreg;
				written_value_q <= res.wval;
				insn_q          <= insn_s2;
			end else begin
				status_q        <= ST_LOADED;
				next_pc_q       <= pc_q;
				index_value_q   <= index_q;
				reg_written_q   <= 1'b0;
				written_reg_q   <= '0;
				written_value_q <= 8'h00;
				insn_q          <= 16'h0000;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign next_pc             = next_pc_q;
	assign index_value         = index_value_q;
	assign reg_written         = reg_written_q;
	assign written_reg         = written_reg_q;
	assign written_value       = written_value_q;
	assign fetched_instruction = insn_q;

endmodule

### rtl/core/chip8fe_prog_mem.sv
// Program memory: even and odd byte banks, two-byte fetch, clearing pass after reset.
module chip8fe_prog_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  chip8fe_pkg::mem_rd_req_t  rd_req,
	input  chip8fe_pkg::mem_wr_req_t  wr_req,
	output logic [7:0]                rd_hi,
	output logic [7:0]                rd_lo,
	output logic                      clearing
);
	import chip8fe_pkg::*;

	logic [7:0] even_mem [BANK_DEPTH];
	logic [7:0] odd_mem  [BANK_DEPTH];

	logic               clr_active_q;
	logic [BANK_AW-1:0] clr_addr_q;
	logic [7:0]         even_rd_q;
	logic [7:0]         odd_rd_q;
	logic               hi_odd_q;

	logic [BANK_AW-1:0] even_rd_addr;
	logic [BANK_AW-1:0] odd_rd_addr;
	logic               hi_odd;
	logic               wr_odd;
	logic [BANK_AW-1:0] wr_bank_addr;

	// High byte lives in the odd bank when the fetch address is odd
	assign hi_odd       = rd_req.hi_addr[0];
	assign even_rd_addr = hi_odd ? rd_req.lo_addr[ADDR_W-1:1] : rd_req.hi_addr[ADDR_W-1:1];
	assign odd_rd_addr  = hi_odd ? rd_req.hi_addr[ADDR_W-1:1] : rd_req.lo_addr[ADDR_W-1:1];
	assign wr_odd       = wr_req.addr[0];
	assign wr_bank_addr = wr_req.addr[ADDR_W-1:1];

	// Clearing pass: one row of both banks per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + BANK_AW'(1);
			if (clr_addr_q == {BANK_AW{1'b1}}) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Even bank
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			even_mem[clr_addr_q] <= 8'h00;
		end else if (wr_req.en && !wr_odd) begin
			even_mem[wr_bank_addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			even_rd_q <= even_mem[even_rd_addr];
		end
	end

	// Odd bank
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			odd_mem[clr_addr_q] <= 8'h00;
		end else if (wr_req.en && wr_odd) begin
			odd_mem[wr_bank_addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			odd_rd_q <= odd_mem[odd_rd_addr];
			hi_odd_q <= hi_odd;
		end
	end

	assign rd_hi    = hi_odd_q ? odd_rd_q : even_rd_q;
	assign rd_lo    = hi_odd_q ? even_rd_q : odd_rd_q;
	assign clearing = clr_active_q;

endmodule

### rtl/core/chip8fe_regfile.sv
// General register file V0..VF: two registered read ports, one write port.
module chip8fe_regfile (
	input  logic                     clk,
	input  logic                     arst_n,
	input  chip8fe_pkg::rf_rd_req_t  rd_req,
	input  chip8fe_pkg::rf_wr_req_t  wr_req,
	output logic [7:0]               rd_a,
	output logic [7:0]               rd_b
);
	import chip8fe_pkg::*;

	logic [7:0]          regs [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [7:0]          rd_a_q;
	logic [7:0]          rd_b_q;

	// Per-entry valid bits: an unwritten register reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_req.en) begin
			valid_q[wr_req.addr] <= 1'b1;
		end
	end

	// Storage and registered reads
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			regs[wr_req.addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			rd_a_q <= valid_q[rd_req.a_addr] ? regs[rd_req.a_addr] : 8'h00;
			rd_b_q <= valid_q[rd_req.b_addr] ? regs[rd_req.b_addr] : 8'h00;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

### rtl/core/chip8fe_execute.sv
// Instruction decode and execute: next pc, index and register write-back.
module chip8fe_execute (
	input  logic [15:0]                          insn,
	input  logic [7:0]                           vx,
	input  logic [7:0]                           vb,
	input  logic [7:0]                           rand_byte,
	input  logic [chip8fe_pkg::PC_W-1:0]         pc,
	input  logic [chip8fe_pkg::PC_W-1:0]         index,
	output chip8fe_pkg::exec_res_t               res
);
	import chip8fe_pkg::*;

	logic [3:0]        op;
	logic [REG_AW-1:0] x;
	logic [7:0]        nn;
	logic [11:0]       nnn;
	logic [PC_W-1:0]   pc_seq;
	logic [PC_W-1:0]   pc_skip;

	assign op      = insn[15:12];
	assign x       = insn[11:8];
	assign nn      = insn[7:0];
	assign nnn     = insn[11:0];
	assign pc_seq  = pc + PC_W'(2);
	assign pc_skip = pc + PC_W'(4);

	// vb carries Vy for the register compares and V0 for the indexed jump
	always_comb begin
		res            = '0;
		res.status     = ST_EXECUTED;
		res.next_pc    = pc_seq;
		res.next_index = index;
		unique case (op)
			OP_JP: res.next_pc = nnn;
			OP_SE_IMM: begin
				if (vx == nn) res.next_pc = pc_skip;
			end
			OP_SNE_IMM: begin
				if (vx != nn) res.next_pc = pc_skip;
			end
			OP_SE_REG: begin
				if (vx == vb) res.next_pc = pc_skip;
			end
			OP_SNE_REG: begin
				if (vx != vb) res.next_pc = pc_skip;
			end
			OP_LD_IMM: begin
				res.reg_wr = 1'b1;
				res.wreg   = x;
				res.wval   = nn;
			end
			OP_ADD_IMM: begin
				res.reg_wr = 1'b1;
				res.wreg   = x;
				res.wval   = vx + nn;
			end
			OP_LD_I: res.next_index = nnn;
			OP_JP_V0: res.next_pc = nnn + {4'h0, vb};
			OP_RND: begin
				res.reg_wr = 1'b1;
				res.wreg   = x;
				res.wval   = rand_byte & nn;
			end
			default: res.status = ST_UNIMPL;
		endcase
	end

endmodule
